[src/ols_pkg.sv]
package ols_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int POS_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);
	localparam int CMD_W   = 3;
	localparam int STAT_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_FIND   = 3'd4,
		CMD_REMOVE = 3'd5,
		CMD_READ   = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// what a cell loads at the next edge
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_UP    = 2'd2,
		CELL_DOWN  = 2'd3
	} cell_op_t;

endpackage

[src/ordered_list_store_unit.sv]
// Ordered list of up to 16 signed 32-bit items, kept in a row of register cells.
// Input channel: in_valid / in_stall with cmd, position and item_value. A beat
// is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with value, found_position, found,
// status and count; one result beat for every command beat.
// Each cell holds one entry, compares it with item_value and can load from its
// lower or upper neighbor, so insert and delete shift the entries from the given
// position upward at once, and find scans all entries at once through a priority encoder.
// The result appears in the output register in the cycle after the command
// beat. One command is taken per cycle while out_stall is low.
// When out_stall is high with a result waiting, in_stall goes high and the
// held result stays unchanged until it is taken.
// Reset clears the entry count and the output valid; entry contents are not
// cleared, and only positions below the count are ever read.
module ordered_list_store_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ols_pkg::CMD_W-1:0]          cmd,
	input  logic [ols_pkg::POS_W-1:0]          position,
	input  logic signed [ols_pkg::DATA_W-1:0]  item_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ols_pkg::DATA_W-1:0]  value,
	output logic [ols_pkg::POS_W-1:0]          found_position,
	output logic                               found,
	output logic [ols_pkg::STAT_W-1:0]         status,
	output logic [ols_pkg::COUNT_W-1:0]        count
);
	import ols_pkg::*;

	logic signed [DATA_W-1:0] entries [DEPTH];
	logic [DEPTH-1:0]         hits;
	cell_op_t                 ops [DEPTH];

	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic [POS_W-1:0]   fpos_q;
	logic               found_q;
	logic [STAT_W-1:0]  status_q;
	logic [COUNT_W-1:0] rcount_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic [POS_W-1:0]   rd_idx;
	logic signed [DATA_W-1:0] rd_val;
	logic [DEPTH-1:0]   live_hits;
	logic [POS_W-1:0]   hit_pos;
	logic               any_hit;

	logic                     ins_en;
	logic [COUNT_W-1:0]       ins_pos;
	logic                     del_en;
	logic [COUNT_W-1:0]       del_pos;
	logic signed [DATA_W-1:0] val_d;
	logic [POS_W-1:0]         fpos_d;
	logic                     found_d;
	status_t                  status_d;
	logic [COUNT_W-1:0]       count_d;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign full     = (count_q == COUNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// pop reads the tail, read reads the given position
	assign rd_idx = (cmd_t'(cmd) == CMD_POP) ? POS_W'(count_q - COUNT_W'(1)) : position;
	assign rd_val = entries[rd_idx];

	always_comb begin
		logic [COUNT_W-1:0] idx;
		idx     = '0;
		hit_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			idx          = COUNT_W'(i);
			live_hits[i] = hits[i] & (idx < count_q);
			if (live_hits[i]) begin
				hit_pos = POS_W'(i);
			end
		end
	end

	assign any_hit = |live_hits;

	always_comb begin
		ins_en   = 1'b0;
		ins_pos  = '0;
		del_en   = 1'b0;
		del_pos  = '0;
		val_d    = '0;
		fpos_d   = '0;
		found_d  = 1'b0;
		status_d = ST_OK;
		count_d  = count_q;
		unique case (cmd_t'(cmd))
			CMD_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_en  = 1'b1;
					ins_pos = count_q;
					count_d = count_q + COUNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					val_d   = rd_val;
					count_d = count_q - COUNT_W'(1);
				end
			end
			CMD_INSERT: begin
				if (COUNT_W'(position) > count_q) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					ins_en  = 1'b1;
					ins_pos = COUNT_W'(position);
					count_d = count_q + COUNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (COUNT_W'(position) >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					del_en  = 1'b1;
					del_pos = COUNT_W'(position);
					val_d   = rd_val;
					count_d = count_q - COUNT_W'(1);
				end
			end
			CMD_FIND, CMD_REMOVE: begin
				if (any_hit) begin
					found_d = 1'b1;
					fpos_d  = hit_pos;
					if (cmd_t'(cmd) == CMD_REMOVE) begin
						// the removed entry equals the searched item
						del_en  = 1'b1;
						del_pos = COUNT_W'(hit_pos);
						val_d   = item_value;
						count_d = count_q - COUNT_W'(1);
					end
				end
			end
			CMD_READ: begin
				if (COUNT_W'(position) >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					val_d = rd_val;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		logic [COUNT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			idx    = COUNT_W'(i);
			ops[i] = CELL_HOLD;
			if (accept && ins_en) begin
				if (idx == ins_pos) begin
					ops[i] = CELL_LOAD;
				end else if (idx > ins_pos && idx <= count_q) begin
					ops[i] = CELL_UP;
				end
			end else if (accept && del_en && idx >= del_pos) begin
				ops[i] = CELL_DOWN;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] prev_w;
		logic signed [DATA_W-1:0] next_w;

		if (g == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid
			assign prev_w = entries[g-1];
		end

		// the top cell has no upper neighbor; what it keeps lies past the count
		if (g == DEPTH - 1) begin : g_last
			assign next_w = entries[g];
		end else begin : g_inner
			assign next_w = entries[g+1];
		end

		ols_cell u_cell (
			.clk        (clk),
			.op         (ops[g]),
			.item_value (item_value),
			.prev_entry (prev_w),
			.next_entry (next_w),
			.entry      (entries[g]),
			.hit        (hits[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result beat while the receiver stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= val_d;
			fpos_q   <= fpos_d;
			found_q  <= found_d;
			status_q <= status_d;
			rcount_q <= count_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign found_position = fpos_q;
	assign found          = found_q;
	assign status         = status_q;
	assign count          = rcount_q;

endmodule

[src/ols_cell.sv]
module ols_cell (
	input  logic                               clk,
	input  ols_pkg::cell_op_t                  op,
	input  logic signed [ols_pkg::DATA_W-1:0]  item_value,
	input  logic signed [ols_pkg::DATA_W-1:0]  prev_entry,
	input  logic signed [ols_pkg::DATA_W-1:0]  next_entry,
	output logic signed [ols_pkg::DATA_W-1:0]  entry,
	output logic                               hit
);
	import ols_pkg::*;

	logic signed [DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD: entry_q <= entry_q;
			CELL_LOAD: entry_q <= item_value;
			CELL_UP:   entry_q <= prev_entry;
			CELL_DOWN: entry_q <= next_entry;
			default:   entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign hit   = (entry_q == item_value);

endmodule
